// ===== design/hpqp_pkg.sv =====
package hpqp_pkg;

  // Default number of histogram bins per image.
  localparam int DEF_BINS = 256;

  // Field widths.
  localparam int CNT_W = 24;
  localparam int IMG_W = 8;
  localparam int POS_W = 9;
  localparam int QN_W  = 4;
  localparam int SUM_W = 32;
  // Wide enough for 100 * sum and for pct * total with pct up to 105.
  localparam int THR_W = SUM_W + 7;

  // Quantiles are FIRST_PCT + STEP_PCT * k percent, k = 0 .. QUANT_COUNT-1.
  localparam int QUANT_COUNT = 10;
  localparam int FIRST_PCT   = 5;
  localparam int STEP_PCT    = 10;

  localparam logic [QN_W-1:0] LAST_QUANT = QN_W'(QUANT_COUNT - 1);
  localparam logic [QN_W-1:0] QUANT_END  = QN_W'(QUANT_COUNT);

  // Controller to datapath commands.
  typedef struct packed {
    logic            accept;     // input request taken this cycle
    logic            last;       // taken request closes the pair
    logic            init;       // prepare thresholds and pointers
    logic            scan;       // one step of the cumulative scan
    logic            emit_load;  // load the output register
    logic [QN_W-1:0] quant;      // quantile to load
  } hpqp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
  } hpqp_status_t;

endpackage

// ===== design/hpqp_ram.sv =====
module hpqp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/hpqp_ctrl.sv =====
module hpqp_ctrl
  import hpqp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_last_bin,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  hpqp_status_t status,
  output hpqp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [QN_W-1:0] quant_r, quant_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;
  logic            load;
  logic            take;

  assign accept = in_valid && (state_r == ST_LOAD);
  assign take   = out_valid_r && !out_stall;
  assign load   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  // Commands to the datapath
  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.last      = in_last_bin;
    cmd.init      = (state_r == ST_INIT);
    cmd.scan      = (state_r == ST_SCAN);
    cmd.emit_load = load;
    cmd.quant     = quant_r;
  end

  // Next state
  always_comb begin
    state_nxt     = state_r;
    quant_nxt     = quant_r;
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last_bin) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = ST_EMIT;
          quant_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          quant_nxt     = quant_r + 1'b1;
          if (quant_r == LAST_QUANT) begin
            state_nxt = ST_LOAD;
            quant_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      quant_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      quant_r     <= quant_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;

endmodule

// ===== design/hpqp_dp.sv =====
module hpqp_dp
  import hpqp_pkg::*;
#(
  parameter int BINS = DEF_BINS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hpqp_cmd_t         cmd,
  output hpqp_status_t      status,
  input  logic [CNT_W-1:0]  in_count_first,
  input  logic [CNT_W-1:0]  in_count_second,
  input  logic [IMG_W-1:0]  in_image_first,
  input  logic [IMG_W-1:0]  in_image_second,
  output logic [QN_W-1:0]   out_quantile_number,
  output logic [POS_W-1:0]  out_position_first,
  output logic [POS_W-1:0]  out_position_second,
  output logic [IMG_W-1:0]  out_image_first_out,
  output logic [IMG_W-1:0]  out_image_second_out,
  output logic              out_last_quantile
);

  localparam int AW = $clog2(BINS);
  localparam int CW = $clog2(BINS + 1);
  localparam logic [CW-1:0]    BINS_CNT = CW'(BINS);
  localparam logic [POS_W-1:0] BINS_POS = POS_W'(BINS % (1 << POS_W));

  // Load side
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0] run1_r, run1_nxt, run2_r, run2_nxt;
  logic [SUM_W-1:0] tot1_r, tot2_r;
  logic [CW-1:0]    n_r;
  logic [IMG_W-1:0] img1_r, img2_r;
  logic [SUM_W:0]   add1, add2;
  logic [SUM_W-1:0] sat1, sat2;
  logic             store;

  // Scan side
  logic [AW-1:0]    idx_r;
  logic [AW-1:0]    raddr;
  logic [QN_W-1:0]  q1_r, q2_r;
  logic [THR_W-1:0] thr1_r, thr2_r, step1_r, step2_r;
  logic [POS_W-1:0] pos1_r [QUANT_COUNT];
  logic [POS_W-1:0] pos2_r [QUANT_COUNT];
  logic [SUM_W-1:0] cum1, cum2;
  logic [THR_W-1:0] c1w, c2w, prod1, prod2;
  logic             done1, done2, hit1, hit2, advance, at_last;

  // Saturating running sums
  assign add1  = {1'b0, run1_r} + (SUM_W + 1)'(in_count_first);
  assign add2  = {1'b0, run2_r} + (SUM_W + 1)'(in_count_second);
  assign sat1  = add1[SUM_W] ? '1 : add1[SUM_W-1:0];
  assign sat2  = add2[SUM_W] ? '1 : add2[SUM_W-1:0];
  assign store = cmd.accept && (cnt_r != BINS_CNT);

  always_comb begin
    cnt_nxt  = cnt_r;
    run1_nxt = run1_r;
    run2_nxt = run2_r;
    if (store) begin
      cnt_nxt  = cnt_r + 1'b1;
      run1_nxt = sat1;
      run2_nxt = sat2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      run1_r <= '0;
      run2_r <= '0;
    end else if (cmd.accept && cmd.last) begin
      cnt_r  <= '0;
      run1_r <= '0;
      run2_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      run1_r <= run1_nxt;
      run2_r <= run2_nxt;
    end
  end

  // Capture pair totals and image indexes on the closing request
  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.last) begin
      tot1_r <= run1_nxt;
      tot2_r <= run2_nxt;
      n_r    <= cnt_nxt;
      img1_r <= in_image_first;
      img2_r <= in_image_second;
    end
  end

  // Cumulative stores
  hpqp_ram #(.WIDTH(SUM_W), .DEPTH(BINS)) u_ram_first (
    .clk   (clk),
    .we    (store),
    .waddr (cnt_r[AW-1:0]),
    .wdata (sat1),
    .raddr (raddr),
    .rdata (cum1)
  );

  hpqp_ram #(.WIDTH(SUM_W), .DEPTH(BINS)) u_ram_second (
    .clk   (clk),
    .we    (store),
    .waddr (cnt_r[AW-1:0]),
    .wdata (sat2),
    .raddr (raddr),
    .rdata (cum2)
  );

  // 100 * cum by shift-add, compared with pct * total
  assign c1w   = THR_W'(cum1);
  assign c2w   = THR_W'(cum2);
  assign prod1 = (c1w << 6) + (c1w << 5) + (c1w << 2);
  assign prod2 = (c2w << 6) + (c2w << 5) + (c2w << 2);

  assign done1   = (q1_r == QUANT_END);
  assign done2   = (q2_r == QUANT_END);
  assign hit1    = !done1 && (prod1 >= thr1_r);
  assign hit2    = !done2 && (prod2 >= thr2_r);
  assign advance = !hit1 && !hit2;
  assign at_last = ((CW'(idx_r) + 1'b1) == n_r);

  assign status.scan_done = (done1 && done2) || (advance && at_last);

  // Read address: hold the bin while it still meets a quantile
  always_comb begin
    raddr = idx_r;
    if (cmd.init) begin
      raddr = '0;
    end else if (cmd.scan && advance) begin
      raddr = idx_r + 1'b1;
    end
  end

  // Scan registers
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      idx_r   <= '0;
      q1_r    <= '0;
      q2_r    <= '0;
      thr1_r  <= (THR_W'(tot1_r) << 2) + THR_W'(tot1_r);
      thr2_r  <= (THR_W'(tot2_r) << 2) + THR_W'(tot2_r);
      step1_r <= (THR_W'(tot1_r) << 3) + (THR_W'(tot1_r) << 1);
      step2_r <= (THR_W'(tot2_r) << 3) + (THR_W'(tot2_r) << 1);
      for (int k = 0; k < QUANT_COUNT; k++) begin
        pos1_r[k] <= BINS_POS;
        pos2_r[k] <= BINS_POS;
      end
    end else if (cmd.scan) begin
      if (hit1) begin
        pos1_r[q1_r] <= POS_W'(idx_r);
        q1_r         <= q1_r + 1'b1;
        thr1_r       <= thr1_r + step1_r;
      end
      if (hit2) begin
        pos2_r[q2_r] <= POS_W'(idx_r);
        q2_r         <= q2_r + 1'b1;
        thr2_r       <= thr2_r + step2_r;
      end
      if (advance) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_quantile_number  <= cmd.quant;
      out_position_first   <= pos1_r[cmd.quant];
      out_position_second  <= pos2_r[cmd.quant];
      out_image_first_out  <= img1_r;
      out_image_second_out <= img2_r;
      out_last_quantile    <= (cmd.quant == LAST_QUANT);
    end
  end

endmodule

// ===== design/histogram_pair_quantile_positions.sv =====
// Histogram pair quantile positions.
// Input channel: one request per bin, carrying both histograms' counts of that
// bin and the two image indexes; in_last_bin marks the final bin of the pair.
// Bins load at one per cycle while the block is in its load phase. Bins beyond
// BINS are ignored (their counts are dropped).
// After the final bin the block runs a setup step and then scans the two
// cumulative stores once, all ten quantiles together, holding a bin while either
// store meets a quantile there. in_stall is high from the final bin until the
// tenth result sits in the output register.
// Output channel: ten results, quantile 5%, 15%, .. 95%, the tenth flagged by
// out_last_quantile, at one result per cycle while the receiver does not stall.
// The scan reads each store through its single read port.
// A stalled result holds in the output register; the next pair may start
// loading while the tenth result still waits.
// Reset (synchronous, rst_n low) clears sums, bin count, state and out_valid.
module histogram_pair_quantile_positions
  import hpqp_pkg::*;
#(
  parameter int BINS = DEF_BINS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CNT_W-1:0]  in_count_first,
  input  logic [CNT_W-1:0]  in_count_second,
  input  logic [IMG_W-1:0]  in_image_first,
  input  logic [IMG_W-1:0]  in_image_second,
  input  logic              in_last_bin,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [QN_W-1:0]   out_quantile_number,
  output logic [POS_W-1:0]  out_position_first,
  output logic [POS_W-1:0]  out_position_second,
  output logic [IMG_W-1:0]  out_image_first_out,
  output logic [IMG_W-1:0]  out_image_second_out,
  output logic              out_last_quantile
);

  hpqp_cmd_t    cmd;
  hpqp_status_t status;

  // Sequencer
  hpqp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_bin (in_last_bin),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Sums, stores, scan and output register
  hpqp_dp #(.BINS(BINS)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_count_first       (in_count_first),
    .in_count_second      (in_count_second),
    .in_image_first       (in_image_first),
    .in_image_second      (in_image_second),
    .out_quantile_number  (out_quantile_number),
    .out_position_first   (out_position_first),
    .out_position_second  (out_position_second),
    .out_image_first_out  (out_image_first_out),
    .out_image_second_out (out_image_second_out),
    .out_last_quantile    (out_last_quantile)
  );

endmodule

// ===== design/hpqp_checker.sv =====
module hpqp_checker
  import hpqp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_last_bin,
  input logic              out_valid,
  input logic              out_stall,
  input logic [QN_W-1:0]   out_quantile_number,
  input logic [POS_W-1:0]  out_position_first,
  input logic [POS_W-1:0]  out_position_second,
  input logic [IMG_W-1:0]  out_image_first_out,
  input logic [IMG_W-1:0]  out_image_second_out,
  input logic              out_last_quantile
);

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quantile_number)
      && $stable(out_position_first) && $stable(out_position_second)
      && $stable(out_image_first_out) && $stable(out_image_second_out)
      && $stable(out_last_quantile))
    else $error("stalled result changed");

  // The pair's closing bin starts the scan; no new bin is taken next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_bin |=> in_stall)
    else $error("bin taken right after closing bin");

  // While earlier results of a pair are pending, input stays stalled.
  a_stall_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_quantile |-> in_stall)
    else $error("bin taken while results pending");

  // The last flag marks exactly the tenth quantile.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_quantile == (out_quantile_number == LAST_QUANT)))
    else $error("last flag mismatch");

  // Next result after a non-final one carries the next quantile number.
  a_quant_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_quantile ##1 out_valid
      |-> out_quantile_number == $past(out_quantile_number) + 1'b1)
    else $error("quantile number out of sequence");

endmodule

bind histogram_pair_quantile_positions hpqp_checker u_hpqp_checker (.*);

// ===== tb/histogram_pair_quantile_positions_test.sv =====
`timescale 1ns / 100ps

module histogram_pair_quantile_positions_test;
  import hpqp_pkg::*;

  localparam int BINS        = DEF_BINS;
  localparam int RANDOM_BINS = 450;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_MAX  = 10;
  localparam int PLAN_ROWS   = 19;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // One bin request as driven on the input channel.
  typedef struct {
    logic [CNT_W-1:0] count_first;
    logic [CNT_W-1:0] count_second;
    logic [IMG_W-1:0] img_first;
    logic [IMG_W-1:0] img_second;
    logic             last;
  } bin_req_t;

  // One quantile position result.
  typedef struct {
    logic [QN_W-1:0]  quant;
    logic [POS_W-1:0] pos_first;
    logic [POS_W-1:0] pos_second;
    logic [IMG_W-1:0] img_first;
    logic [IMG_W-1:0] img_second;
    logic             last_q;
  } quantile_pos_t;

  // Directed row; typed rows carry positions that hold for all ten quantiles.
  typedef struct {
    logic [CNT_W-1:0] cf;
    logic [CNT_W-1:0] cs;
    logic [IMG_W-1:0] imf;
    logic [IMG_W-1:0] ims;
    logic             last;
    bit               typed;
    logic [POS_W-1:0] pf;
    logic [POS_W-1:0] ps;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CNT_W-1:0] in_count_first = '0;
  logic [CNT_W-1:0] in_count_second = '0;
  logic [IMG_W-1:0] in_image_first = '0;
  logic [IMG_W-1:0] in_image_second = '0;
  logic             in_last_bin = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [QN_W-1:0]  out_quantile_number;
  logic [POS_W-1:0] out_position_first;
  logic [POS_W-1:0] out_position_second;
  logic [IMG_W-1:0] out_image_first_out;
  logic [IMG_W-1:0] out_image_second_out;
  logic             out_last_quantile;

  // Predictor state: cumulative sums of the pair being loaded.
  logic [SUM_W-1:0] cum_first_q [BINS];
  logic [SUM_W-1:0] cum_second_q [BINS];
  int unsigned      bins_held = 0;
  logic [SUM_W-1:0] run_first = '0;
  logic [SUM_W-1:0] run_second = '0;
  quantile_pos_t    pair_result [QUANT_COUNT];
  quantile_pos_t    expected_positions [$];

  int  faults = 0;
  int  results_seen = 0;
  int  bins_sent = 0;
  int  pairs_done = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  // Directed part: zero totals, count extremes, image extremes, equality hits.
  plan_row_t plan [PLAN_ROWS] = '{
    '{0, 0, 8'h00, 8'h00, 1, 1, 0, 0},
    '{CNT_MAX, CNT_MAX, 8'hFF, 8'hFF, 1, 1, 0, 0},
    '{0, CNT_MAX, 8'h12, 8'h34, 0, 0, 0, 0},
    '{CNT_MAX, 0, 8'hA5, 8'h5A, 1, 1, 1, 0},
    '{0, 0, 8'h01, 8'h02, 0, 0, 0, 0},
    '{0, 0, 8'hFE, 8'h01, 0, 0, 0, 0},
    '{0, 0, 8'h55, 8'hAA, 0, 0, 0, 0},
    '{7, 9, 8'h80, 8'h7F, 1, 1, 3, 3},
    '{0, 5, 8'h3C, 8'hC3, 0, 0, 0, 0},
    '{0, 0, 8'h3C, 8'hC3, 1, 1, 0, 0},
    '{1, 1, 8'h11, 8'h22, 0, 0, 0, 0},
    '{19, 3, 8'h11, 8'h22, 1, 0, 0, 0},
    '{1, 8, 8'h40, 8'h04, 0, 0, 0, 0},
    '{1, 4, 8'h40, 8'h04, 0, 0, 0, 0},
    '{1, 2, 8'h40, 8'h04, 0, 0, 0, 0},
    '{1, 1, 8'h40, 8'h04, 1, 0, 0, 0},
    '{CNT_MAX, 1, 8'h0F, 8'hF0, 0, 0, 0, 0},
    '{CNT_MAX, CNT_MAX, 8'h0F, 8'hF0, 0, 0, 0, 0},
    '{1, CNT_MAX, 8'hF0, 8'h0F, 1, 0, 0, 0}
  };

  histogram_pair_quantile_positions uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_count_first       (in_count_first),
    .in_count_second      (in_count_second),
    .in_image_first       (in_image_first),
    .in_image_second      (in_image_second),
    .in_last_bin          (in_last_bin),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_quantile_number  (out_quantile_number),
    .out_position_first   (out_position_first),
    .out_position_second  (out_position_second),
    .out_image_first_out  (out_image_first_out),
    .out_image_second_out (out_image_second_out),
    .out_last_quantile    (out_last_quantile)
  );

  always #1 clk = ~clk;

  // Running sum that sticks at all ones.
  function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // First stored bin with 100 * cum >= pct * total.
  function automatic logic [POS_W-1:0] first_reaching(input bit second,
                                                      input int unsigned pct);
    logic [SUM_W-1:0]  total;
    longint unsigned   need;
    longint unsigned   reach;
    total = second ? run_second : run_first;
    if (total == '0) return '0;
    need = longint'(pct) * longint'(total);
    for (int i = 0; i < bins_held; i++) begin
      reach = 100 * longint'(second ? cum_second_q[i] : cum_first_q[i]);
      if (reach >= need) return POS_W'(i);
    end
    return POS_W'(BINS);
  endfunction

  // Takes one accepted bin; returns 1 and fills pair_result when the pair closes.
  function automatic bit absorb_bin(input bin_req_t r);
    if (bins_held < BINS) begin
      run_first  = sat_sum(run_first, r.count_first);
      run_second = sat_sum(run_second, r.count_second);
      cum_first_q[bins_held]  = run_first;
      cum_second_q[bins_held] = run_second;
      bins_held++;
    end
    if (!r.last) return 1'b0;
    for (int k = 0; k < QUANT_COUNT; k++) begin
      pair_result[k].quant      = QN_W'(k);
      pair_result[k].pos_first  = first_reaching(1'b0, FIRST_PCT + STEP_PCT * k);
      pair_result[k].pos_second = first_reaching(1'b1, FIRST_PCT + STEP_PCT * k);
      pair_result[k].img_first  = r.img_first;
      pair_result[k].img_second = r.img_second;
      pair_result[k].last_q     = (QN_W'(k) == LAST_QUANT);
    end
    bins_held  = 0;
    run_first  = '0;
    run_second = '0;
    return 1'b1;
  endfunction

  // Mix of zero, full scale, small and wide counts.
  function automatic logic [CNT_W-1:0] draw_count();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CNT_MAX;
      2, 3, 4: return CNT_W'($urandom_range(0, 15));
      default: return CNT_W'($urandom);
    endcase
  endfunction

  // Drive one request and wait for it to be taken.
  task automatic send_bin(input bin_req_t r, input bit typed,
                          input logic [POS_W-1:0] pf, input logic [POS_W-1:0] ps);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_count_first  <= r.count_first;
    in_count_second <= r.count_second;
    in_image_first  <= r.img_first;
    in_image_second <= r.img_second;
    in_last_bin     <= r.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bins_sent++;
    if (absorb_bin(r)) begin
      pairs_done++;
      for (int k = 0; k < QUANT_COUNT; k++) begin
        if (typed) begin
          pair_result[k].pos_first  = pf;
          pair_result[k].pos_second = ps;
        end
        expected_positions.insert(expected_positions.size(), pair_result[k]);
      end
    end
  endtask

  // Compare a taken result with the oldest expectation.
  task automatic check_result();
    quantile_pos_t want;
    results_seen++;
    if (expected_positions.size() == 0) begin
      faults++;
      if (faults <= REPORT_MAX)
        $display("Unexpected result %0d: q=%0d pos=%0d/%0d", results_seen,
                 out_quantile_number, out_position_first, out_position_second);
      return;
    end
    want = expected_positions.pop_front();
    if (out_quantile_number !== want.quant || out_position_first !== want.pos_first ||
        out_position_second !== want.pos_second ||
        out_image_first_out !== want.img_first ||
        out_image_second_out !== want.img_second ||
        out_last_quantile !== want.last_q) begin
      faults++;
      if (faults <= REPORT_MAX) begin
        $display("Mismatch at result %0d", results_seen);
        $display("  expected q=%0d pos=%0d/%0d img=%0d/%0d lastq=%0b", want.quant,
                 want.pos_first, want.pos_second, want.img_first, want.img_second,
                 want.last_q);
        $display("  actual   q=%0d pos=%0d/%0d img=%0d/%0d lastq=%0b",
                 out_quantile_number, out_position_first, out_position_second,
                 out_image_first_out, out_image_second_out, out_last_quantile);
      end
    end
  endtask

  // Result side: check, then hold off for a random number of cycles.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result();
      stall_left = rx_calm ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               expected_positions.size());
      $display("** histogram_pair_quantile_positions: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    bin_req_t r;
    int       pair_len;
    int       pair_idx;
    int       rnd_bins;
    bit       blank_first;
    bit       blank_second;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (plan[i]) begin
      r = '{plan[i].cf, plan[i].cs, plan[i].imf, plan[i].ims, plan[i].last};
      send_bin(r, plan[i].typed, plan[i].pf, plan[i].ps);
    end

    // Random pairs, mostly short; one runs past BINS so the excess is dropped
    pair_idx = 0;
    rnd_bins = 0;
    while (rnd_bins < RANDOM_BINS) begin
      if (pair_idx == 3)
        pair_len = BINS + $urandom_range(1, 4);
      else if ($urandom_range(0, 9) < 7)
        pair_len = $urandom_range(1, 8);
      else
        pair_len = $urandom_range(9, 40);
      blank_first  = ($urandom_range(0, 7) == 0);
      blank_second = ($urandom_range(0, 7) == 0);
      for (int b = 0; b < pair_len; b++) begin
        r.count_first  = blank_first ? '0 : draw_count();
        r.count_second = blank_second ? '0 : draw_count();
        r.img_first    = IMG_W'($urandom);
        r.img_second   = IMG_W'($urandom);
        r.last         = (b == pair_len - 1);
        send_bin(r, 1'b0, '0, '0);
      end
      rnd_bins += pair_len;
      pair_idx++;
    end
    in_valid <= 1'b0;

    // Drain
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_positions.size() != 0) begin
      faults += expected_positions.size();
      $display("%0d expected results never arrived", expected_positions.size());
    end

    $display("Sent %0d bin requests in %0d histogram pairs; %0d quantile results checked.",
             bins_sent, pairs_done, results_seen);
    $display("Covered zero totals, full-scale counts, short pairs and a pair past %0d bins.",
             BINS);
    if (faults == 0) begin
      $display("** histogram_pair_quantile_positions: PASSED **");
    end else begin
      $display("%0d failures", faults);
      $display("** histogram_pair_quantile_positions: FAILED **");
    end
    $finish;
  end

endmodule
